// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the checker file spa_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spa_pkg.sv =====
// ---------------------------------------------------------------------------
// spa_pkg
// types and constants of the sprite attribute pixel mapper
// ---------------------------------------------------------------------------
package spa_pkg;

    // transaction command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // register byte map
    localparam int REG_COUNT = 8;
    localparam logic [2:0] REG_TILE0   = 3'd0;
    localparam logic [2:0] REG_TILE1   = 3'd1;
    localparam logic [2:0] REG_XPOS_LO = 3'd2;
    localparam logic [2:0] REG_XPOS_HI = 3'd3;
    localparam logic [2:0] REG_YPOS_LO = 3'd4;
    localparam logic [2:0] REG_YPOS_HI = 3'd5;
    localparam logic [2:0] REG_ATTR    = 3'd6;
    localparam logic [2:0] REG_CTRL    = 3'd7;

    // control byte bits
    localparam int CTRL_TWO_TILES = 0;
    localparam int CTRL_HORIZ     = 1;
    localparam int CTRL_SCALE_X   = 2;
    localparam int CTRL_SCALE_Y   = 3;
    localparam int CTRL_PRIO_LO   = 4;
    localparam int CTRL_ENABLE    = 7;

    // per-tile attribute nibble bits
    localparam int ATTR_VFLIP = 2;
    localparam int ATTR_HFLIP = 3;

    // rotation codes
    localparam logic [1:0] ROT_NONE    = 2'd0;
    localparam logic [1:0] ROT_QUARTER = 2'd1;
    localparam logic [1:0] ROT_THREEQ  = 2'd2;
    localparam logic [1:0] ROT_HALF    = 2'd3;

    typedef logic [REG_COUNT-1:0][7:0] reg_file_t;

    // pixel query result
    typedef struct packed {
        logic       hit;
        logic [7:0] tile_number;
        logic [3:0] texel_x;
        logic [3:0] texel_y;
        logic [1:0] layer_priority;
    } map_result_t;

endpackage

// ===== design/sprite_attribute_pixel_mapper.sv =====
// ---------------------------------------------------------------------------
// sprite_attribute_pixel_mapper
// eight-byte sprite register file with a screen-to-texel pixel mapper
// ---------------------------------------------------------------------------
// Usage: one input channel (in_valid / in_stall) carries a command with its
// register address, write byte and screen coordinate; one output channel
// (out_valid / out_stall) returns exactly one result transaction per input.
// Write stores a register byte and returns zeros, read returns the byte,
// a pixel query returns hit, tile index, source texel and priority bits.
// An accepted transaction moves from the input register on to the result
// register, which raises out_valid, whenever the result register is free
// or being taken. Throughput: one transaction per cycle while the receiver
// does not stall, limited by the single mapper pass between the two
// registers; a write is seen by the very next transaction.
// Reset clears all eight register bytes and both valid flags.
// When the receiver stalls, the result holds; the input register keeps one
// more transaction, after which in_stall rises until the output drains.
// ---------------------------------------------------------------------------
module sprite_attribute_pixel_mapper
    import spa_pkg::*;
#(
    parameter int TILE_EDGE = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [2:0]  reg_address,
    input  logic [7:0]  write_data,
    input  logic [15:0] screen_x,
    input  logic [15:0] screen_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        hit,
    output logic [7:0]  tile_number,
    output logic [3:0]  texel_x,
    output logic [3:0]  texel_y,
    output logic [1:0]  layer_priority
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_command_reg;
    logic [2:0]  s1_address_reg;
    logic [7:0]  s1_data_reg;
    logic [15:0] s1_x_reg;
    logic [15:0] s1_y_reg;
    reg_file_t   regs_reg;
    reg_file_t   regs_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    map_result_t result_reg;
    map_result_t result_next;
    logic [7:0]  read_data_reg;
    logic [7:0]  read_data_next;
    logic        advance;
    logic        in_take;
    map_result_t query;

    // stage 1 moves on when the result register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // pixel mapping on the registered coordinate
    spa_mapper #(
        .TILE_EDGE (TILE_EDGE)
    ) u_spa_mapper (
        .sprite_regs (regs_reg),
        .screen_x    (s1_x_reg),
        .screen_y    (s1_y_reg),
        .result      (query)
    );

    // command decode, register write and result selection
    always_comb
    begin
        regs_next      = regs_reg;
        result_next    = '0;
        read_data_next = 8'd0;
        unique case (cmd_t'(s1_command_reg))
            CMD_WRITE:
            begin
                if (s1_valid_reg && advance)
                begin
                    regs_next[s1_address_reg] = s1_data_reg;
                end
            end
            CMD_READ:
            begin
                read_data_next = regs_reg[s1_address_reg];
            end
            CMD_QUERY:
            begin
                result_next = query;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // valid flags, an empty input register fills even while the output stalls
    always_comb
    begin
        s1_valid_next  = s1_valid_reg && !advance;
        out_valid_next = out_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // control state and register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            regs_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            regs_reg      <= regs_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_command_reg <= command;
            s1_address_reg <= reg_address;
            s1_data_reg    <= write_data;
            s1_x_reg       <= screen_x;
            s1_y_reg       <= screen_y;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            result_reg    <= result_next;
            read_data_reg <= read_data_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign hit            = result_reg.hit;
    assign tile_number    = result_reg.tile_number;
    assign texel_x        = result_reg.texel_x;
    assign texel_y        = result_reg.texel_y;
    assign layer_priority = result_reg.layer_priority;

endmodule

// ===== design/spa_mapper.sv =====
// ---------------------------------------------------------------------------
// spa_mapper
// maps a screen coordinate to tile index and source texel of the sprite
// ---------------------------------------------------------------------------
module spa_mapper
    import spa_pkg::*;
#(
    parameter int TILE_EDGE = 16
)
(
    input  reg_file_t   sprite_regs,
    input  logic [15:0] screen_x,
    input  logic [15:0] screen_y,
    output map_result_t result
);

    localparam int CW = $clog2(TILE_EDGE);
    localparam int TW = (CW > 4) ? CW : 4;
    localparam logic [15:0] EDGE  = 16'(TILE_EDGE);
    localparam logic [15:0] EDGE2 = 16'(2 * TILE_EDGE);
    localparam logic [TW-1:0] LAST = TW'(TILE_EDGE - 1);

    logic [7:0]    ctrl;
    logic [15:0]   pos_x;
    logic [15:0]   pos_y;
    logic [15:0]   diff_x;
    logic [15:0]   diff_y;
    logic [15:0]   dx;
    logic [15:0]   dy;
    logic [15:0]   lim_x;
    logic [15:0]   lim_y;
    logic [15:0]   ox;
    logic [15:0]   oy;
    logic          wide_x;
    logic          tall_y;
    logic          in_sprite;
    logic          tile_sel;
    logic [3:0]    attr;
    logic [TW-1:0] x;
    logic [TW-1:0] y;
    logic [TW-1:0] u;
    logic [TW-1:0] v;

    // sprite geometry from the register bytes
    assign ctrl   = sprite_regs[REG_CTRL];
    assign pos_x  = {sprite_regs[REG_XPOS_HI], sprite_regs[REG_XPOS_LO]};
    assign pos_y  = {sprite_regs[REG_YPOS_HI], sprite_regs[REG_YPOS_LO]};
    assign wide_x = ctrl[CTRL_TWO_TILES] & ctrl[CTRL_HORIZ];
    assign tall_y = ctrl[CTRL_TWO_TILES] & ~ctrl[CTRL_HORIZ];
    assign lim_x  = wide_x ? EDGE2 : EDGE;
    assign lim_y  = tall_y ? EDGE2 : EDGE;

    // offset into sprite space, halved on a scaled axis
    assign diff_x = screen_x - pos_x;
    assign diff_y = screen_y - pos_y;
    assign dx     = ctrl[CTRL_SCALE_X] ? {1'b0, diff_x[15:1]} : diff_x;
    assign dy     = ctrl[CTRL_SCALE_Y] ? {1'b0, diff_y[15:1]} : diff_y;

    assign in_sprite = ctrl[CTRL_ENABLE] && (screen_x >= pos_x) && (screen_y >= pos_y)
                       && (dx < lim_x) && (dy < lim_y);

    // second tile along the attach axis
    assign tile_sel = (wide_x && dx >= EDGE) || (tall_y && dy >= EDGE);
    assign ox       = (wide_x && dx >= EDGE) ? dx - EDGE : dx;
    assign oy       = (tall_y && dy >= EDGE) ? dy - EDGE : dy;
    assign attr     = tile_sel ? sprite_regs[REG_ATTR][7:4] : sprite_regs[REG_ATTR][3:0];

    // undo flips
    assign x = attr[ATTR_HFLIP] ? LAST - ox[TW-1:0] : ox[TW-1:0];
    assign y = attr[ATTR_VFLIP] ? LAST - oy[TW-1:0] : oy[TW-1:0];

    // undo rotation
    always_comb
    begin
        case (attr[1:0])
            ROT_QUARTER:
            begin
                u = LAST - y;
                v = x;
            end
            ROT_THREEQ:
            begin
                u = y;
                v = LAST - x;
            end
            ROT_HALF:
            begin
                u = LAST - x;
                v = LAST - y;
            end
            default:
            begin
                u = x;
                v = y;
            end
        endcase
    end

    // misses report only the priority bits
    always_comb
    begin
        result.layer_priority = ctrl[CTRL_PRIO_LO +: 2];
        result.hit            = in_sprite;
        result.tile_number    = 8'd0;
        result.texel_x        = 4'd0;
        result.texel_y        = 4'd0;
        if (in_sprite)
        begin
            result.tile_number = tile_sel ? sprite_regs[REG_TILE1] : sprite_regs[REG_TILE0];
            result.texel_x     = u[3:0];
            result.texel_y     = v[3:0];
        end
    end

endmodule

// ===== design/spa_checker.sv =====
// ---------------------------------------------------------------------------
// spa_checker
// port-level checks of the sprite attribute pixel mapper
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  command,
    input logic [2:0]  reg_address,
    input logic [7:0]  write_data,
    input logic [15:0] screen_x,
    input logic [15:0] screen_y,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data,
    input logic        hit,
    input logic [7:0]  tile_number,
    input logic [3:0]  texel_x,
    input logic [3:0]  texel_y,
    input logic [1:0]  layer_priority
);

    // a stalled result transaction stays and holds its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(read_data) && $stable(hit) && $stable(tile_number)
        && $stable(texel_x) && $stable(texel_y) && $stable(layer_priority),
        "result changed while stalled")

    // input backpressure only while the output side is blocked
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall,
        "input stalled without a blocked output")

    // a miss carries no tile or texel
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, out_valid && !hit,
        tile_number == 8'd0 && texel_x == 4'd0 && texel_y == 4'd0,
        "miss with nonzero tile or texel")

    // read data and query fields never appear together
    `ASSERT_IMPLIES(a_read_excl, clk, rst_n, out_valid && read_data != 8'd0,
        !hit && layer_priority == 2'd0,
        "read result mixed with query result")

endmodule

bind sprite_attribute_pixel_mapper spa_checker u_spa_checker (.*);

// ===== tb/sprite_attribute_pixel_mapper_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_attribute_pixel_mapper_test
// drives writes, reads, pixel queries and the spare command code through the
// input channel with random gaps and output stalls, predicts every result
// from a shadow copy of the sprite registers and checks results in order
// ----------------------------------------------------------------------------
module sprite_attribute_pixel_mapper_test;
    import spa_pkg::*;

    localparam int          EDGE        = 16;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RAND_ITEMS  = 1700;
    localparam int          REPORT_MAX  = 10;
    localparam logic [1:0]  CMD_SPARE   = 2'd3;

    // one expected or observed result transaction
    typedef struct packed {
        logic [7:0]  read_data;
        map_result_t map;
    } sprite_result_t;

    // shadow register file, pixel mapper prediction and in-order result check
    class sprite_result_tracker;
        reg_file_t      regs = '0;
        sprite_result_t pending_results[$];
        int             mismatches = 0;
        int             n_write = 0;
        int             n_read = 0;
        int             n_query = 0;
        int             n_hit = 0;
        int             n_spare = 0;

        function automatic map_result_t predict_pixel(logic [15:0] sx, logic [15:0] sy);
            logic [7:0]  ctrl;
            logic [15:0] px;
            logic [15:0] py;
            logic        two;
            logic        horiz;
            logic        tile;
            logic [3:0]  attr;
            int unsigned wt;
            int unsigned ht;
            int unsigned dx;
            int unsigned dy;
            int unsigned x;
            int unsigned y;
            int unsigned u;
            int unsigned v;
            map_result_t r;
            r = '0;
            ctrl = regs[REG_CTRL];
            px = {regs[REG_XPOS_HI], regs[REG_XPOS_LO]};
            py = {regs[REG_YPOS_HI], regs[REG_YPOS_LO]};
            r.layer_priority = ctrl[CTRL_PRIO_LO +: 2];
            if (!ctrl[CTRL_ENABLE] || sx < px || sy < py)
                return r;
            two = ctrl[CTRL_TWO_TILES];
            horiz = ctrl[CTRL_HORIZ];
            dx = 32'(sx - px) >> ctrl[CTRL_SCALE_X];
            dy = 32'(sy - py) >> ctrl[CTRL_SCALE_Y];
            wt = (two && horiz) ? 2 * EDGE : EDGE;
            ht = (two && !horiz) ? 2 * EDGE : EDGE;
            if (dx >= wt || dy >= ht)
                return r;
            // pick the tile along the attach axis
            tile = 1'b0;
            if (two && horiz && dx >= EDGE)
            begin
                tile = 1'b1;
                dx -= EDGE;
            end
            if (two && !horiz && dy >= EDGE)
            begin
                tile = 1'b1;
                dy -= EDGE;
            end
            attr = tile ? regs[REG_ATTR][7:4] : regs[REG_ATTR][3:0];
            // undo flips, then rotation
            x = attr[ATTR_HFLIP] ? EDGE - 1 - dx : dx;
            y = attr[ATTR_VFLIP] ? EDGE - 1 - dy : dy;
            case (attr[1:0])
                ROT_QUARTER:
                begin
                    u = EDGE - 1 - y;
                    v = x;
                end
                ROT_THREEQ:
                begin
                    u = y;
                    v = EDGE - 1 - x;
                end
                ROT_HALF:
                begin
                    u = EDGE - 1 - x;
                    v = EDGE - 1 - y;
                end
                default:
                begin
                    u = x;
                    v = y;
                end
            endcase
            r.hit = 1'b1;
            r.tile_number = regs[tile ? REG_TILE1 : REG_TILE0];
            r.texel_x = u[3:0];
            r.texel_y = v[3:0];
            return r;
        endfunction

        // accepted input transaction: update shadow state, queue its result
        function void note_input(logic [1:0] cmd, logic [2:0] addr, logic [7:0] wdata,
                                 logic [15:0] sx, logic [15:0] sy);
            sprite_result_t e;
            e = '0;
            case (cmd)
                CMD_WRITE:
                begin
                    regs[addr] = wdata;
                    n_write++;
                end
                CMD_READ:
                begin
                    e.read_data = regs[addr];
                    n_read++;
                end
                CMD_QUERY:
                begin
                    e.map = predict_pixel(sx, sy);
                    n_query++;
                    if (e.map.hit)
                        n_hit++;
                end
                default:
                    n_spare++;
            endcase
            pending_results.push_back(e);
        endfunction

        function void report(string what, sprite_result_t e, sprite_result_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t mismatch (%s): exp rd=%h hit=%b tile=%h tx=%h ty=%h pri=%h, got rd=%h hit=%b tile=%h tx=%h ty=%h pri=%h",
                         $realtime, what, e.read_data, e.map.hit, e.map.tile_number,
                         e.map.texel_x, e.map.texel_y, e.map.layer_priority,
                         got.read_data, got.map.hit, got.map.tile_number,
                         got.map.texel_x, got.map.texel_y, got.map.layer_priority);
        endfunction

        // accepted result transaction: compare with the oldest expectation
        function void check_result(sprite_result_t got);
            sprite_result_t e;
            if (pending_results.size() == 0)
            begin
                report("no result expected", '0, got);
                return;
            end
            e = pending_results.pop_front();
            if (got.read_data !== e.read_data || got.map.hit !== e.map.hit
                || got.map.tile_number !== e.map.tile_number
                || got.map.texel_x !== e.map.texel_x || got.map.texel_y !== e.map.texel_y
                || got.map.layer_priority !== e.map.layer_priority)
                report("field", e, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [2:0]  reg_address;
    logic [7:0]  write_data;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        hit;
    logic [7:0]  tile_number;
    logic [3:0]  texel_x;
    logic [3:0]  texel_y;
    logic [1:0]  layer_priority;

    sprite_result_tracker sb = new;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int stall_left = 0;
    int cycles = 0;

    sprite_attribute_pixel_mapper #(
        .TILE_EDGE(EDGE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .reg_address(reg_address),
        .write_data(write_data),
        .screen_x(screen_x),
        .screen_y(screen_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .hit(hit),
        .tile_number(tile_number),
        .texel_x(texel_x),
        .texel_y(texel_y),
        .layer_priority(layer_priority)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver stall bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (rx_idle_on && rst_n && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            out_stall <= (stall_left > 0);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({read_data, hit, tile_number, texel_x, texel_y, layer_priority});
    end

    // present one transaction and hold it until accepted
    task automatic send_item(logic [1:0] cmd, logic [2:0] addr, logic [7:0] wdata,
                             logic [15:0] sx, logic [15:0] sy);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        reg_address <= addr;
        write_data  <= wdata;
        screen_x    <= sx;
        screen_y    <= sy;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(cmd, addr, wdata, sx, sy);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [7:0] data);
        send_item(CMD_WRITE, addr, data, 16'($urandom), 16'($urandom));
    endtask

    task automatic query(logic [15:0] sx, logic [15:0] sy);
        send_item(CMD_QUERY, 3'($urandom), 8'($urandom), sx, sy);
    endtask

    // sender holds off until every expected result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() > 0)
            @(posedge clk);
    endtask

    // one random transaction, mostly queries aimed at the sprite
    task automatic send_random();
        int          k;
        logic [15:0] px;
        logic [15:0] py;
        logic [2:0]  addr;
        logic [7:0]  data;
        k = $urandom_range(0, 99);
        px = {sb.regs[REG_XPOS_HI], sb.regs[REG_XPOS_LO]};
        py = {sb.regs[REG_YPOS_HI], sb.regs[REG_YPOS_LO]};
        addr = 3'($urandom);
        data = 8'($urandom);
        if (k < 9)
        begin
            // keep rendering on most of the time
            if (addr == REG_CTRL && $urandom_range(0, 4) != 0)
                data[CTRL_ENABLE] = 1'b1;
            write_reg(addr, data);
        end
        else if (k < 17)
            send_item(CMD_READ, addr, data, 16'($urandom), 16'($urandom));
        else if (k < 20)
            send_item(CMD_SPARE, addr, data, 16'($urandom), 16'($urandom));
        else if (k < 80)
            query(16'(px + $urandom_range(0, 4 * EDGE + 3) - 2),
                  16'(py + $urandom_range(0, 4 * EDGE + 3) - 2));
        else
            query(16'($urandom), 16'($urandom));
    endtask

    // stimulus
    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_WRITE;
        reg_address <= REG_TILE0;
        write_data  <= '0;
        screen_x    <= '0;
        screen_y    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: zero registers, disabled sprite, spare command
        send_item(CMD_READ, REG_CTRL, 8'h00, 16'hFFFF, 16'hFFFF);
        query(16'h0000, 16'h0000);
        send_item(CMD_SPARE, 3'h7, 8'hFF, 16'hFFFF, 16'hFFFF);

        // single tile at (0x0100, 0x0080), enabled, priority three
        write_reg(REG_TILE0, 8'hA5);
        write_reg(REG_TILE1, 8'h5A);
        write_reg(REG_XPOS_LO, 8'h00);
        write_reg(REG_XPOS_HI, 8'h01);
        write_reg(REG_YPOS_LO, 8'h80);
        write_reg(REG_YPOS_HI, 8'h00);
        write_reg(REG_ATTR, 8'h00);
        write_reg(REG_CTRL, 8'hB0);
        query(16'h0100, 16'h0080);
        query(16'h00FF, 16'h0080);
        query(16'h0100, 16'h007F);
        query(16'h0110, 16'h0080);

        // every rotation code, flips on odd codes
        for (int rot = 0; rot < 4; rot++)
        begin
            write_reg(REG_ATTR, {2'(rot), 2'(rot), rot[0], rot[0], 2'(rot)});
            query(16'h0103, 16'h0085);
        end

        // two tiles side by side with 2x scale, then stacked
        write_reg(REG_CTRL, 8'h8F);
        query(16'h0100 + 16'd41, 16'h0080 + 16'd6);
        write_reg(REG_CTRL, 8'hA1);
        query(16'h0102, 16'h0080 + 16'd20);

        // x position at the top of the coordinate range
        write_reg(REG_XPOS_LO, 8'hFF);
        write_reg(REG_XPOS_HI, 8'hFF);
        query(16'hFFFF, 16'h008F);
        drain_results();

        // random part in phases, some without idling, none at the end
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_idle_on = (i < RAND_ITEMS - 200) && ($urandom_range(0, 3) != 0);
                rx_idle_on = (i < RAND_ITEMS - 200) && ($urandom_range(0, 3) != 0);
            end
            if (i == RAND_ITEMS / 2)
                drain_results();
            send_random();
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d writes, %0d reads, %0d pixel queries (%0d hits), %0d spare commands",
                 sb.n_write, sb.n_read, sb.n_query, sb.n_hit, sb.n_spare);
        $display("%0d mismatches over %0d cycles", sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sprite_attribute_pixel_mapper.f =====
+incdir+design
design/spa_pkg.sv
design/spa_mapper.sv
design/sprite_attribute_pixel_mapper.sv
design/spa_checker.sv
tb/sprite_attribute_pixel_mapper_test.sv
